// ----- rtl/core/icmp_echo_responder_top_defines.svh -----
`ifndef ICMP_ECHO_RESPONDER_TOP_DEFINES_SVH
`define ICMP_ECHO_RESPONDER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define IER_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icmp echo responder: check failed");

// Next-cycle implication, checked outside reset
`define IER_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icmp echo responder: check failed");

`endif

// ----- rtl/core/ier_pkg.sv -----
`timescale 1ns / 1ps

package ier_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 1024;
    localparam logic [9:0]  COUNT_MAX        = 10'h3ff;
    localparam logic [9:0]  MIN_WORDS        = 10'd10;
    localparam logic [7:0]  PROTO_ICMP       = 8'd1;
    localparam logic [7:0]  PROTO_UDP        = 8'd17;
    localparam logic [7:0]  ICMP_ECHO        = 8'd8;
    localparam logic [15:0] ID_RESET         = 16'd23;
    localparam logic [15:0] SUM_GOOD         = 16'hffff;

    // header word positions
    localparam logic [9:0] W_IHL   = 10'd0;
    localparam logic [9:0] W_TOTAL = 10'd1;
    localparam logic [9:0] W_ID    = 10'd2;
    localparam logic [9:0] W_PROTO = 10'd4;
    localparam logic [9:0] W_CSUM  = 10'd5;
    localparam logic [9:0] W_SRC_H = 10'd6;
    localparam logic [9:0] W_SRC_L = 10'd7;
    localparam logic [9:0] W_DST_H = 10'd8;
    localparam logic [9:0] W_DST_L = 10'd9;

    typedef enum logic [2:0] {
        VERDICT_UDP       = 3'd0,
        VERDICT_BAD_HSUM  = 3'd1,
        VERDICT_BAD_ISUM  = 3'd2,
        VERDICT_BAD_LEN   = 3'd3,
        VERDICT_NOT_ECHO  = 3'd4,
        VERDICT_ECHO_RPLY = 3'd5,
        VERDICT_OTHER     = 3'd6
    } verdict_t;

    // packet summary handed from the accumulator to the evaluator
    typedef struct packed {
        logic [9:0]  word_cnt;
        logic [5:0]  hdr_bytes;
        logic [15:0] total_bytes;
        logic [7:0]  proto;
        logic [15:0] hdr_sum;
        logic [15:0] rply_hdr_sum;   // kept header words plus source address
        logic [15:0] icmp_sum;
        logic [15:0] icmp_rply_sum;
        logic [7:0]  icmp_type;
        logic [31:0] src_ip;
        logic [47:0] mac;
    } fin_t;

    // ones'-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        oc_add = s[16] ? (s[15:0] + 16'd1) : s[15:0];
    endfunction

    function automatic logic [15:0] oc_sum4(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] c, input logic [15:0] d);
        logic [17:0] t;
        logic [16:0] x;
        t = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
        x = {1'b0, t[15:0]} + {15'd0, t[17:16]};
        oc_sum4 = x[16] ? (x[15:0] + 16'd1) : x[15:0];
    endfunction

endpackage

// ----- rtl/core/icmp_echo_responder_top.sv -----
`timescale 1ns / 1ps

// IPv4 receive dispatcher with ICMP echo reply. Takes one 16-bit packet word per
// cycle while in_ready is high, with no gaps needed between packets; the throughput
// is set by the ones'-complement adds per word into the running header and ICMP
// sums. One result transfer follows each word marked last, which passes through
// the input register, the packet summary register and the result register. Reply
// fields are zero unless the verdict is echo reply. my_ip may be written only
// while no packet is in flight.

module icmp_echo_responder_top
    import ier_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] packet_word,
    input  logic        word_last,
    input  logic [47:0] peer_mac,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  verdict,
    output logic [31:0] reply_dst_ip,
    output logic [31:0] reply_src_ip,
    output logic [15:0] reply_ip_id,
    output logic [15:0] reply_ip_checksum,
    output logic [15:0] reply_icmp_checksum,
    output logic [47:0] reply_dst_mac
);

    logic [31:0] my_ip_reg;
    logic        fin_valid;
    logic        fin_ready;
    fin_t        fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_ip_reg <= '0;
        end
        else if (cfg_we)
        begin
            my_ip_reg <= cfg_data;
        end
    end

    ier_acc u_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .packet_word (packet_word),
        .word_last   (word_last),
        .peer_mac    (peer_mac),
        .fin_valid   (fin_valid),
        .fin_ready   (fin_ready),
        .fin         (fin)
    );

    ier_eval u_eval (
        .clk                 (clk),
        .rst_n               (rst_n),
        .fin_valid           (fin_valid),
        .fin_ready           (fin_ready),
        .fin                 (fin),
        .my_ip               (my_ip_reg),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .verdict             (verdict),
        .reply_dst_ip        (reply_dst_ip),
        .reply_src_ip        (reply_src_ip),
        .reply_ip_id         (reply_ip_id),
        .reply_ip_checksum   (reply_ip_checksum),
        .reply_icmp_checksum (reply_icmp_checksum),
        .reply_dst_mac       (reply_dst_mac)
    );

endmodule

// ----- rtl/core/ier_acc.sv -----
`timescale 1ns / 1ps

module ier_acc
    import ier_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] packet_word,
    input  logic        word_last,
    input  logic [47:0] peer_mac,
    output logic        fin_valid,
    input  logic        fin_ready,
    output fin_t        fin
);

    logic        in_valid_reg;
    logic [15:0] in_word_reg;
    logic        in_last_reg;
    logic [47:0] in_mac_reg;

    logic [9:0]  word_cnt_reg,  word_cnt_next;
    logic [5:0]  hdr_bytes_reg, hdr_bytes_next;
    logic [15:0] total_reg,     total_next;
    logic [7:0]  proto_reg,     proto_next;
    logic [15:0] hsum_reg,      hsum_next;
    logic [15:0] rsum_reg,      rsum_next;
    logic [15:0] isum_reg,      isum_next;
    logic [15:0] irsum_reg,     irsum_next;
    logic [7:0]  itype_reg,     itype_next;
    logic [31:0] src_reg,       src_next;
    logic [47:0] mac_reg,       mac_next;

    logic        fin_valid_reg;
    fin_t        fin_reg;

    logic        go;
    logic [9:0]  idx;
    logic [9:0]  hw;
    logic        active;
    logic        is_hdr;
    logic        is_icmp;
    logic        rel0;
    logic        rel1;

    assign go       = in_valid_reg && (!in_last_reg || !fin_valid_reg || fin_ready);
    assign in_ready = !in_valid_reg || go;

    always_comb
    begin
        idx            = word_cnt_reg;
        hdr_bytes_next = (idx == W_IHL)   ? {in_word_reg[11:8], 2'b00} : hdr_bytes_reg;
        total_next     = (idx == W_TOTAL) ? in_word_reg : total_reg;
        proto_next     = (idx == W_PROTO) ? in_word_reg[7:0] : proto_reg;
        mac_next       = (idx == W_IHL)   ? in_mac_reg : mac_reg;
        src_next       = src_reg;
        if (idx == W_SRC_H)
        begin
            src_next = {in_word_reg, src_reg[15:0]};
        end
        else if (idx == W_SRC_L)
        begin
            src_next = {src_reg[31:16], in_word_reg};
        end

        hw      = {5'd0, hdr_bytes_next[5:1]};
        active  = (idx != COUNT_MAX);
        is_hdr  = idx < hw;
        is_icmp = !is_hdr && ({6'd0, idx} < {1'b0, total_next[15:1]});
        rel0    = (idx == hw);
        rel1    = (idx == hw + 10'd1);

        hsum_next  = hsum_reg;
        rsum_next  = rsum_reg;
        isum_next  = isum_reg;
        irsum_next = irsum_reg;
        itype_next = itype_reg;
        word_cnt_next = idx;

        if (active)
        begin
            word_cnt_next = idx + 10'd1;
            if (is_hdr)
            begin
                hsum_next = oc_add(hsum_reg, in_word_reg);
                if (idx != W_ID && idx != W_CSUM && idx != W_DST_H && idx != W_DST_L)
                begin
                    rsum_next = oc_add(rsum_reg, in_word_reg);
                end
            end
            else if (is_icmp)
            begin
                isum_next = oc_add(isum_reg, in_word_reg);
                if (rel0)
                begin
                    itype_next = in_word_reg[15:8];
                    irsum_next = oc_add(irsum_reg, {8'd0, in_word_reg[7:0]});
                end
                else if (!rel1)
                begin
                    irsum_next = oc_add(irsum_reg, in_word_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            word_cnt_reg  <= '0;
            hdr_bytes_reg <= '0;
            total_reg     <= '0;
            proto_reg     <= '0;
            hsum_reg      <= '0;
            rsum_reg      <= '0;
            isum_reg      <= '0;
            irsum_reg     <= '0;
            itype_reg     <= '0;
            src_reg       <= '0;
            mac_reg       <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (go && in_last_reg)
            begin
                fin_valid_reg <= 1'b1;
            end
            else if (fin_ready)
            begin
                fin_valid_reg <= 1'b0;
            end
            if (go)
            begin
                if (in_last_reg)
                begin
                    word_cnt_reg  <= '0;
                    hdr_bytes_reg <= '0;
                    total_reg     <= '0;
                    proto_reg     <= '0;
                    hsum_reg      <= '0;
                    rsum_reg      <= '0;
                    isum_reg      <= '0;
                    irsum_reg     <= '0;
                    itype_reg     <= '0;
                    src_reg       <= '0;
                    mac_reg       <= '0;
                end
                else
                begin
                    word_cnt_reg  <= word_cnt_next;
                    hdr_bytes_reg <= hdr_bytes_next;
                    total_reg     <= total_next;
                    proto_reg     <= proto_next;
                    hsum_reg      <= hsum_next;
                    rsum_reg      <= rsum_next;
                    isum_reg      <= isum_next;
                    irsum_reg     <= irsum_next;
                    itype_reg     <= itype_next;
                    src_reg       <= src_next;
                    mac_reg       <= mac_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_word_reg <= packet_word;
            in_last_reg <= word_last;
            in_mac_reg  <= peer_mac;
        end
        if (go && in_last_reg)
        begin
            fin_reg.word_cnt      <= word_cnt_next;
            fin_reg.hdr_bytes     <= hdr_bytes_next;
            fin_reg.total_bytes   <= total_next;
            fin_reg.proto         <= proto_next;
            fin_reg.hdr_sum       <= hsum_next;
            fin_reg.rply_hdr_sum  <= rsum_next;
            fin_reg.icmp_sum      <= isum_next;
            fin_reg.icmp_rply_sum <= irsum_next;
            fin_reg.icmp_type     <= itype_next;
            fin_reg.src_ip        <= src_next;
            fin_reg.mac           <= mac_next;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

endmodule

// ----- rtl/core/ier_eval.sv -----
`timescale 1ns / 1ps

module ier_eval
    import ier_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fin_valid,
    output logic        fin_ready,
    input  fin_t        fin,
    input  logic [31:0] my_ip,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  verdict,
    output logic [31:0] reply_dst_ip,
    output logic [31:0] reply_src_ip,
    output logic [15:0] reply_ip_id,
    output logic [15:0] reply_ip_checksum,
    output logic [15:0] reply_icmp_checksum,
    output logic [47:0] reply_dst_mac
);

    logic        out_valid_reg;
    logic [15:0] id_reg;
    verdict_t    verdict_reg;
    logic [31:0] dst_ip_reg;
    logic [31:0] src_ip_reg;
    logic [15:0] ip_id_reg;
    logic [15:0] ip_csum_reg;
    logic [15:0] icmp_csum_reg;
    logic [47:0] dst_mac_reg;

    verdict_t    verdict_next;
    logic        bad_len;
    logic        take;
    logic        is_reply;
    logic [16:0] min_total;

    assign fin_ready = !out_valid_reg || out_ready;
    assign take      = fin_valid && fin_ready;

    always_comb
    begin
        min_total = {11'd0, fin.hdr_bytes} + 17'd8;
        bad_len   = (fin.hdr_bytes < 6'd20) ||
                    ({1'b0, fin.total_bytes} < min_total) ||
                    ({16'd0, fin.total_bytes} > 32'(MAX_PACKET_BYTES)) ||
                    ({5'd0, fin.word_cnt, 1'b0} < fin.total_bytes);
        if (fin.word_cnt < MIN_WORDS)
        begin
            verdict_next = VERDICT_BAD_LEN;
        end
        else if (fin.proto == PROTO_UDP)
        begin
            verdict_next = VERDICT_UDP;
        end
        else if (fin.proto != PROTO_ICMP)
        begin
            verdict_next = VERDICT_OTHER;
        end
        else if (bad_len)
        begin
            verdict_next = VERDICT_BAD_LEN;
        end
        else if (fin.hdr_sum != SUM_GOOD)
        begin
            verdict_next = VERDICT_BAD_HSUM;
        end
        else if (fin.icmp_sum != SUM_GOOD)
        begin
            verdict_next = VERDICT_BAD_ISUM;
        end
        else if (fin.icmp_type != ICMP_ECHO)
        begin
            verdict_next = VERDICT_NOT_ECHO;
        end
        else
        begin
            verdict_next = VERDICT_ECHO_RPLY;
        end
        is_reply = (verdict_next == VERDICT_ECHO_RPLY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            id_reg        <= ID_RESET;
        end
        else
        begin
            if (fin_ready)
            begin
                out_valid_reg <= fin_valid;
            end
            if (take && is_reply)
            begin
                id_reg <= id_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            verdict_reg   <= verdict_next;
            dst_ip_reg    <= is_reply ? fin.src_ip : '0;
            src_ip_reg    <= is_reply ? my_ip : '0;
            ip_id_reg     <= is_reply ? id_reg : '0;
            ip_csum_reg   <= is_reply ?
                             ~oc_sum4(fin.rply_hdr_sum, id_reg, my_ip[31:16], my_ip[15:0]) :
                             '0;
            icmp_csum_reg <= is_reply ? ~fin.icmp_rply_sum : '0;
            dst_mac_reg   <= is_reply ? fin.mac : '0;
        end
    end

    assign out_valid           = out_valid_reg;
    assign verdict             = verdict_reg;
    assign reply_dst_ip        = dst_ip_reg;
    assign reply_src_ip        = src_ip_reg;
    assign reply_ip_id         = ip_id_reg;
    assign reply_ip_checksum   = ip_csum_reg;
    assign reply_icmp_checksum = icmp_csum_reg;
    assign reply_dst_mac       = dst_mac_reg;

endmodule

// ----- rtl/core/ier_checker.sv -----
`timescale 1ns / 1ps

`include "icmp_echo_responder_top_defines.svh"

module ier_checker
    import ier_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] packet_word,
    input  logic        word_last,
    input  logic [47:0] peer_mac,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  verdict,
    input  logic [31:0] reply_dst_ip,
    input  logic [31:0] reply_src_ip,
    input  logic [15:0] reply_ip_id,
    input  logic [15:0] reply_ip_checksum,
    input  logic [15:0] reply_icmp_checksum,
    input  logic [47:0] reply_dst_mac
);

    // stalled result transfer keeps its verdict and reply IP identification
    `IER_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(verdict) && $stable(reply_ip_id))

    `IER_ASSERT_NOW(a_verdict_range, out_valid, verdict != 3'd7)

    // only an echo reply carries reply header fields
    `IER_ASSERT_NOW(a_zero_unless_reply, out_valid && verdict != VERDICT_ECHO_RPLY, reply_dst_ip == 32'd0 && reply_src_ip == 32'd0 && reply_ip_id == 16'd0 && reply_ip_checksum == 16'd0 && reply_icmp_checksum == 16'd0 && reply_dst_mac == 48'd0)

    // a result needs a last word, so an idle input side after reset shows no result
    `IER_ASSERT_NEXT(a_no_spurious_out, !out_valid && !in_valid && !$past(in_valid) && !$past(in_valid, 2), !out_valid)

endmodule

bind icmp_echo_responder_top ier_checker u_ier_checker (.*);
